FILE: design/bcld_pkg.sv
`default_nettype none

package bcld_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned EV_W      = 4;
	localparam int unsigned ST_W      = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LONG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_W-1:0] FIRST_LONG_RST = 16'd1000;
	localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd300;
	localparam logic [CFG_W-1:0] REPEAT_MAX     = 16'hFFFF;

	// Button states.
	localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
	localparam logic [ST_W-1:0] ST_QUALIFY = 3'd1;
	localparam logic [ST_W-1:0] ST_ON      = 3'd2;
	localparam logic [ST_W-1:0] ST_LONG    = 3'd3;
	localparam logic [ST_W-1:0] ST_GAP     = 3'd4;
	localparam logic [ST_W-1:0] ST_ON2     = 3'd5;
	localparam logic [ST_W-1:0] ST_LONG2   = 3'd6;

	// Event codes.
	localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
	localparam logic [EV_W-1:0] EV_PRESSED  = 4'd1;
	localparam logic [EV_W-1:0] EV_CLICK    = 4'd2;
	localparam logic [EV_W-1:0] EV_DOUBLE   = 4'd3;
	localparam logic [EV_W-1:0] EV_LONG     = 4'd4;
	localparam logic [EV_W-1:0] EV_LONGREL  = 4'd5;
	localparam logic [EV_W-1:0] EV_LONG2    = 4'd6;
	localparam logic [EV_W-1:0] EV_LONG2REL = 4'd7;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] first_long_time;
		logic [CFG_W-1:0] repeat_time;
	} cfg_t;

	typedef struct packed {
		logic [EV_W-1:0]  event_code;
		logic [CFG_W-1:0] repeat_count;
		logic             switch_on;
	} res_t;

endpackage

`default_nettype wire

FILE: design/bcld_core.sv
`default_nettype none

module bcld_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic                         pin_high,
	input  wire logic [bcld_pkg::TIME_W-1:0]  now_ms,
	input  wire bcld_pkg::cfg_t               cfg,
	output bcld_pkg::res_t                    res
);
	import bcld_pkg::*;

	logic [ST_W-1:0]   state_q, state_d;
	logic [TIME_W-1:0] entry_q, entry_d;
	logic [CFG_W-1:0]  dl_q, dl_d;
	logic [CFG_W-1:0]  rep_q, rep_d;
	logic              sw_q, sw_d;
	logic [EV_W-1:0]   ev;
	logic [TIME_W-1:0] t;
	logic [TIME_W-1:0] dl_ext;
	logic              dl_zero;
	logic [CFG_W-1:0]  rep_inc;

	assign t       = now_ms - entry_q;
	assign dl_ext  = {{(TIME_W-CFG_W){1'b0}}, dl_q};
	assign dl_zero = (dl_q == '0);
	assign rep_inc = (rep_q == REPEAT_MAX) ? rep_q : rep_q + 1'b1;

	always_comb begin
		state_d = state_q;
		entry_d = entry_q;
		dl_d    = dl_q;
		rep_d   = rep_q;
		sw_d    = sw_q;
		ev      = EV_NONE;
		unique case (state_q)
			ST_QUALIFY: begin
				if (pin_high) begin
					state_d = ST_IDLE;
					entry_d = now_ms;
					dl_d    = cfg.debounce_time;
				end else if (t != '0) begin
					entry_d = now_ms;
					// The elapsed time eats into what is left of the qualify time.
					if (t >= dl_ext) begin
						sw_d    = 1'b1;
						ev      = EV_PRESSED;
						state_d = ST_ON;
						dl_d    = cfg.debounce_time;
					end else begin
						dl_d = dl_q - t[CFG_W-1:0];
					end
				end
			end
			ST_ON: begin
				if (t > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time}) begin
					if (pin_high) begin
						if (dl_zero) begin
							state_d = ST_GAP;
							entry_d = now_ms;
							dl_d    = cfg.debounce_time;
						end else begin
							dl_d = dl_q - 1'b1;
						end
					end else begin
						dl_d = cfg.debounce_time;
						if ({{(TIME_W-CFG_W){1'b0}}, cfg.first_long_time} < t) begin
							rep_d   = '0;
							ev      = EV_LONG;
							state_d = ST_LONG;
							entry_d = now_ms;
						end
					end
				end
			end
			ST_LONG, ST_LONG2: begin
				if (pin_high) begin
					if (dl_zero) begin
						sw_d    = 1'b0;
						ev      = (state_q == ST_LONG) ? EV_LONGREL : EV_LONG2REL;
						state_d = ST_IDLE;
						entry_d = now_ms;
						dl_d    = cfg.debounce_time;
					end else begin
						dl_d = dl_q - 1'b1;
					end
				end else begin
					dl_d = cfg.debounce_time;
					if (t > {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_time}) begin
						entry_d = now_ms;
						rep_d   = rep_inc;
						ev      = (state_q == ST_LONG) ? EV_LONG : EV_LONG2;
					end
				end
			end
			ST_GAP: begin
				if (dl_ext < t) begin
					if (!pin_high) begin
						state_d = ST_ON2;
						entry_d = now_ms;
						dl_d    = cfg.debounce_time;
					end else if (t > {{(TIME_W-CFG_W+1){1'b0}},
						cfg.first_long_time[CFG_W-1:1]}) begin
						sw_d    = 1'b0;
						ev      = EV_CLICK;
						state_d = ST_IDLE;
						entry_d = now_ms;
						dl_d    = cfg.debounce_time;
					end
				end
			end
			ST_ON2: begin
				if (dl_ext < t) begin
					if (pin_high) begin
						sw_d    = 1'b0;
						ev      = EV_DOUBLE;
						state_d = ST_IDLE;
						entry_d = now_ms;
						dl_d    = cfg.debounce_time;
					end else if (t > {{(TIME_W-CFG_W){1'b0}}, cfg.first_long_time}) begin
						rep_d   = '0;
						ev      = EV_LONG2;
						state_d = ST_LONG2;
						entry_d = now_ms;
						dl_d    = cfg.debounce_time;
					end
				end
			end
			default: begin
				// Idle, and the one code with no meaning, which behaves as idle.
				state_d = ST_IDLE;
				if (!pin_high) begin
					state_d = ST_QUALIFY;
					entry_d = now_ms;
					dl_d    = cfg.debounce_time;
				end
			end
		endcase
	end

	always_comb begin
		res.event_code   = ev;
		res.repeat_count = (ev == EV_LONG || ev == EV_LONG2) ? rep_d : '0;
		res.switch_on    = sw_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_q <= '0;
			dl_q    <= DEBOUNCE_RST;
			rep_q   <= '0;
			sw_q    <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			entry_q <= entry_d;
			dl_q    <= dl_d;
			rep_q   <= rep_d;
			sw_q    <= sw_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/button_click_longpress_detector.sv
`default_nettype none

// Button click and long-press detector. Each input transaction is one poll of the
// button (pin_high low means pressed, now_ms a free-running millisecond time) and
// gives exactly one result transaction carrying an event code, the long-press
// repeat number and the toggle level. A poll may be taken on every clock cycle
// unless in_stall holds it; a result passes through one input register and then
// one result register, and the whole per-poll decision is a single pass of
// compare and subtract logic on the button state between those registers.
// The three timing registers are written through the configuration port, which is
// always ready; write them only while no poll is in flight.
module button_click_longpress_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           pin_high,
	input  wire logic [bcld_pkg::TIME_W-1:0]    now_ms,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [bcld_pkg::EV_W-1:0]           event_code,
	output logic [bcld_pkg::CFG_W-1:0]          repeat_count,
	output logic                                switch_on,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bcld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bcld_pkg::CFG_W-1:0]     cfg_data
);
	import bcld_pkg::*;

	cfg_t              cfg_q;
	logic              v_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] now_s1;
	logic              adv;
	logic              in_take;
	logic              out_valid_q;
	res_t              res;
	res_t              res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RST;
			cfg_q.first_long_time <= FIRST_LONG_RST;
			cfg_q.repeat_time     <= REPEAT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_time   <= cfg_data;
				REG_FIRST_LONG: cfg_q.first_long_time <= cfg_data;
				REG_REPEAT:     cfg_q.repeat_time     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The poll in the input register moves on whenever the result register is free
	// or is being emptied in this cycle.
	assign adv      = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1 <= pin_high;
			now_s1 <= now_ms;
		end
	end

	bcld_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.pin_high (pin_s1),
		.now_ms   (now_s1),
		.cfg      (cfg_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = res_q.event_code;
	assign repeat_count = res_q.repeat_count;
	assign switch_on    = res_q.switch_on;

	a_rep_only_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeat_count != '0 |-> event_code == EV_LONG || event_code == EV_LONG2)
		else $error("repeat count given with an event that is not a long press");

	a_release_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == EV_CLICK || event_code == EV_DOUBLE ||
		event_code == EV_LONGREL || event_code == EV_LONG2REL) |-> !switch_on)
		else $error("toggle level still on at a release event");

	a_press_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_PRESSED |-> switch_on)
		else $error("toggle level off at a press event");

	a_take_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted poll missing from the input register");

endmodule

`default_nettype wire
